// ===== hdl/adj_nn_pkg.sv =====
// Shared types and constants for the adjacency table nearest-neighbor block.
// Used by adj_nn_ctrl, adj_nn_dp and adjacency_table_nearest_neighbour_top.
// No dependencies.
package adj_nn_pkg;

  // Fixed port widths
  localparam int NODE_IN_W = 6;
  localparam int WEIGHT_W  = 16;

  // Default sizing
  localparam int DEF_NODE_COUNT  = 64;
  localparam int DEF_MAX_DEGREE  = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_DEG,
    ST_CHECK,
    ST_WRITE_SRC,
    ST_WRITE_DST,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic deg_load;
    logic wr_src;
    logic wr_dst;
    logic scan_rd;
    logic set_full;
    logic set_empty;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic directed;
    logic room;
    logic deg_zero;
    logic scan_last;
  } dp_stat_t;

endpackage

// ===== hdl/adj_nn_ctrl.sv =====
// Controller state machine for the adjacency table block.
// Depends on adj_nn_pkg; drives adj_nn_dp through dp_cmd_t.
module adj_nn_ctrl import adj_nn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_READ_DEG;
      end
      ST_READ_DEG: state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.is_query) begin
          state_next = stat.deg_zero ? ST_REPORT : ST_SCAN;
        end else begin
          state_next = stat.room ? ST_WRITE_SRC : ST_REPORT;
        end
      end
      ST_WRITE_SRC: state_next = stat.directed ? ST_REPORT : ST_WRITE_DST;
      ST_WRITE_DST: state_next = ST_REPORT;
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_READ_DEG: cmd.deg_load = 1'b1;
      ST_CHECK: begin
        cmd.set_empty = stat.is_query && stat.deg_zero;
        cmd.set_full  = !stat.is_query && !stat.room;
      end
      ST_WRITE_SRC: cmd.wr_src  = 1'b1;
      ST_WRITE_DST: cmd.wr_dst  = 1'b1;
      ST_SCAN:      cmd.scan_rd = 1'b1;
      ST_DRAIN:     cmd         = '0;
      ST_REPORT:    done        = 1'b1;
      default:      cmd         = '0;
    endcase
  end

endmodule

// ===== hdl/adj_nn_dp.sv =====
// Datapath for the adjacency table block: degree memory, entry memory,
// input registers, minimum search and result registers. Depends on adj_nn_pkg.
module adj_nn_dp import adj_nn_pkg::*; #(
  parameter int NODE_COUNT  = DEF_NODE_COUNT,
  parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  command,
  input  logic [NODE_IN_W-1:0]  src_node,
  input  logic [NODE_IN_W-1:0]  dst_node,
  input  logic [WEIGHT_W-1:0]   edge_weight,
  input  logic                  is_directed,
  output logic [1:0]            status,
  output logic                  found,
  output logic [NODE_IN_W-1:0]  closest_node,
  output logic [WEIGHT_W-1:0]   nearest_weight
);

  localparam int NodeW     = $clog2(NODE_COUNT);
  localparam int DegW      = $clog2(MAX_DEGREE + 1);
  localparam int SlotTotal = NODE_COUNT * MAX_DEGREE;
  localparam int AddrW     = $clog2(SlotTotal);
  localparam int StoreW    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int EntW      = NodeW + StoreW;
  localparam logic [DegW:0]  MaxDegWide = (DegW + 1)'(MAX_DEGREE);
  localparam logic [AddrW-1:0] DegStride = AddrW'(MAX_DEGREE);

  // Wrap a node index modulo NODE_COUNT by shifted compare and subtract
  function automatic logic [NodeW-1:0] wrap_node(input logic [NODE_IN_W-1:0] v);
    logic [NODE_IN_W-1:0]       r;
    logic [NodeW+NODE_IN_W-1:0] t;
    r = v;
    for (int k = NODE_IN_W - 1; k >= 0; k--) begin
      if (int'(r) >= (NODE_COUNT << k)) r = r - NODE_IN_W'(NODE_COUNT << k);
    end
    t = {NodeW'(0), r};
    return t[NodeW-1:0];
  endfunction

  // Latched item
  command_t           cmd_q;
  logic [NodeW-1:0]   src_q;
  logic [NodeW-1:0]   dst_q;
  logic [StoreW-1:0]  w_q;
  logic               directed_q;

  // Degree memory
  logic [DegW-1:0]    deg_mem [NODE_COUNT];
  logic [DegW-1:0]    deg_src_q;
  logic [DegW-1:0]    deg_dst_q;
  logic [NodeW-1:0]   clear_addr;
  logic [NodeW-1:0]   deg_wr_addr;
  logic [DegW-1:0]    deg_wr_data;
  logic [DegW-1:0]    deg_dst_eff;
  logic               room_c;

  // Entry memory
  logic [EntW-1:0]    ent_mem [SlotTotal];
  logic [EntW-1:0]    ent_q;
  logic               rd_valid;
  logic [AddrW-1:0]   base_src;
  logic [AddrW-1:0]   base_dst;
  logic [AddrW-1:0]   ent_wr_addr;
  logic [EntW-1:0]    ent_wr_data;
  logic [AddrW-1:0]   ent_rd_addr;
  logic [DegW-1:0]    idx;

  // Result
  status_t            status_q;
  logic               found_q;
  logic [NodeW-1:0]   best_n;
  logic [StoreW-1:0]  best_w;
  logic [NodeW-1:0]   ent_n;
  logic [StoreW-1:0]  ent_w;
  logic [NodeW+NODE_IN_W-1:0]  node_ext;
  logic [StoreW+WEIGHT_W-1:0]  weight_ext;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q      <= command_t'(command);
      src_q      <= wrap_node(src_node);
      dst_q      <= wrap_node(dst_node);
      w_q        <= edge_weight[StoreW-1:0];
      directed_q <= is_directed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + NodeW'(1);
    end
  end

  assign deg_dst_eff = (src_q == dst_q) ? deg_src_q + DegW'(1) : deg_dst_q;

  always_comb begin
    if (cmd.clear_wr) begin
      deg_wr_addr = clear_addr;
      deg_wr_data = '0;
    end else if (cmd.wr_src) begin
      deg_wr_addr = src_q;
      deg_wr_data = deg_src_q + DegW'(1);
    end else begin
      deg_wr_addr = dst_q;
      deg_wr_data = deg_dst_eff + DegW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr || cmd.wr_src || cmd.wr_dst) deg_mem[deg_wr_addr] <= deg_wr_data;
    if (cmd.deg_load) begin
      deg_src_q <= deg_mem[src_q];
      deg_dst_q <= deg_mem[dst_q];
    end
  end

  // Slot addresses
  assign base_src = AddrW'(src_q) * DegStride;
  assign base_dst = AddrW'(dst_q) * DegStride;

  always_comb begin
    if (cmd.wr_src) begin
      ent_wr_addr = base_src + AddrW'(deg_src_q);
      ent_wr_data = {dst_q, w_q};
    end else begin
      ent_wr_addr = base_dst + AddrW'(deg_dst_eff);
      ent_wr_data = {src_q, w_q};
    end
  end

  assign ent_rd_addr = base_src + AddrW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.wr_src || cmd.wr_dst) ent_mem[ent_wr_addr] <= ent_wr_data;
    ent_q <= ent_mem[ent_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.scan_rd) begin
        idx <= idx + DegW'(1);
      end
    end
  end

  assign ent_n = ent_q[EntW-1:StoreW];
  assign ent_w = ent_q[StoreW-1:0];

  // Keep the first strict minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      status_q <= STATUS_OK;
      found_q  <= 1'b0;
      best_n   <= '0;
      best_w   <= '0;
    end else if (cmd.capture) begin
      status_q <= STATUS_OK;
      found_q  <= 1'b0;
      best_n   <= '0;
      best_w   <= '0;
    end else begin
      if (cmd.set_full)  status_q <= STATUS_FULL;
      if (cmd.set_empty) status_q <= STATUS_EMPTY;
      if (rd_valid && (!found_q || ent_w < best_w)) begin
        found_q <= 1'b1;
        best_n  <= ent_n;
        best_w  <= ent_w;
      end
    end
  end

  assign stat.clear_last = (clear_addr == NodeW'(NODE_COUNT - 1));
  assign stat.is_query   = (cmd_q == CMD_QUERY);
  assign stat.directed   = directed_q;
  assign stat.deg_zero   = (deg_src_q == '0);
  assign stat.scan_last  = ((idx + DegW'(1)) == deg_src_q);
  assign stat.room       = room_c;

  always_comb begin
    if (directed_q) begin
      room_c = ({1'b0, deg_src_q} < MaxDegWide);
    end else if (src_q == dst_q) begin
      room_c = ({1'b0, deg_src_q} + (DegW + 1)'(2) <= MaxDegWide);
    end else begin
      room_c = ({1'b0, deg_src_q} < MaxDegWide) && ({1'b0, deg_dst_q} < MaxDegWide);
    end
  end

  assign node_ext       = {NODE_IN_W'(0), best_n};
  assign weight_ext     = {WEIGHT_W'(0), best_w};
  assign status         = status_q;
  assign found          = found_q;
  assign closest_node   = node_ext[NODE_IN_W-1:0];
  assign nearest_weight = weight_ext[WEIGHT_W-1:0];

endmodule

// ===== hdl/adjacency_table_nearest_neighbour_top.sv =====
// Weighted adjacency table with nearest-neighbor query, top level.
// Depends on adj_nn_pkg, adj_nn_ctrl and adj_nn_dp.
//
// Pulse start with busy low to hand in one item: command 0 appends an edge
// (both directions unless is_directed), command 1 returns the lowest-weight
// neighbor of src_node, first minimum in insertion order winning. Node indexes
// wrap modulo NODE_COUNT and weights keep their low WEIGHT_BITS bits. Each item
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall it, so capture it on that cycle. After reset the block
// sweeps the degree memory to zero, one node per cycle, and holds busy high
// until the sweep ends. An add reads both degrees, checks for room and writes
// the source list and, unless is_directed, the destination list (two writes
// through the single entry-memory write port); a query walks the list of
// src_node, reading one stored entry per cycle through the entry memory's
// single read port. A new item is taken only after the last one has given
// its result.
module adjacency_table_nearest_neighbour_top import adj_nn_pkg::*; #(
  parameter int NODE_COUNT  = DEF_NODE_COUNT,
  parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic [NODE_IN_W-1:0] src_node,
  input  logic [NODE_IN_W-1:0] dst_node,
  input  logic [WEIGHT_W-1:0]  edge_weight,
  input  logic                 is_directed,
  output logic                 done,
  output logic [1:0]           status,
  output logic                 found,
  output logic [NODE_IN_W-1:0] closest_node,
  output logic [WEIGHT_W-1:0]  nearest_weight
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence clear, lookup, write and scan steps
  adj_nn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the tables and compute the result fields
  adj_nn_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .MAX_DEGREE  (MAX_DEGREE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .command        (command),
    .src_node       (src_node),
    .dst_node       (dst_node),
    .edge_weight    (edge_weight),
    .is_directed    (is_directed),
    .status         (status),
    .found          (found),
    .closest_node   (closest_node),
    .nearest_weight (nearest_weight)
  );

endmodule

// ===== tb/adj_nn_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the adjacency table nearest-neighbor testbench: a mirror of
// the edge lists and a queue of the answers it predicts. Depends on adj_nn_pkg.
package adj_nn_tb_pkg;
  import adj_nn_pkg::*;

  localparam int NODES  = DEF_NODE_COUNT;
  localparam int DEGREE = DEF_MAX_DEGREE;
  localparam int WBITS  = DEF_WEIGHT_BITS;

  typedef struct {
    status_t              status;
    logic                 found;
    logic [NODE_IN_W-1:0] node;
    logic [WEIGHT_W-1:0]  weight;
  } answer_t;

  class adjacency_mirror;
    int unsigned          degree [NODES];
    logic [NODE_IN_W-1:0] nbr [NODES][DEGREE];
    logic [WEIGHT_W-1:0]  wt [NODES][DEGREE];
    answer_t              answer_queue [$];
    int errors;
    int adds_stored;
    int adds_full;
    int hits;
    int misses;

    function new();
      foreach (degree[i]) degree[i] = 0;
      errors = 0;
      adds_stored = 0;
      adds_full = 0;
      hits = 0;
      misses = 0;
    endfunction

    function void append(int unsigned n, int unsigned nb, logic [WEIGHT_W-1:0] w);
      nbr[n][degree[n]] = NODE_IN_W'(nb);
      wt[n][degree[n]]  = w;
      degree[n]++;
    endfunction

    // Predict the answer to one accepted item and update the mirrored lists.
    function void apply_command(command_t cmd, logic [NODE_IN_W-1:0] src_in,
                                logic [NODE_IN_W-1:0] dst_in,
                                logic [WEIGHT_W-1:0] w_in, logic directed);
      int unsigned s;
      int unsigned d;
      int unsigned best;
      logic [WEIGHT_W-1:0] w;
      bit room;
      answer_t a;
      s = src_in % NODES;
      d = dst_in % NODES;
      w = w_in & WEIGHT_W'((64'd1 << WBITS) - 1);
      a = '{STATUS_OK, 1'b0, '0, '0};
      if (cmd == CMD_ADD) begin
        if (directed)
          room = degree[s] < DEGREE;
        else if (s == d)
          room = degree[s] + 2 <= DEGREE;
        else
          room = degree[s] < DEGREE && degree[d] < DEGREE;
        if (!room) begin
          a.status = STATUS_FULL;
          adds_full++;
        end else begin
          append(s, d, w);
          if (!directed) append(d, s, w);
          adds_stored++;
        end
      end else if (degree[s] == 0) begin
        a.status = STATUS_EMPTY;
        misses++;
      end else begin
        best = 0;
        for (int i = 1; i < degree[s]; i++)
          if (wt[s][i] < wt[s][best]) best = i;
        a.found  = 1'b1;
        a.node   = nbr[s][best];
        a.weight = wt[s][best];
        hits++;
      end
      answer_queue = {answer_queue, a};
    endfunction

    function void field_check(string name, logic [WEIGHT_W-1:0] exp_v,
                              logic [WEIGHT_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one result against the oldest predicted answer.
    function void check_answer(logic [1:0] status, logic found,
                               logic [NODE_IN_W-1:0] node, logic [WEIGHT_W-1:0] weight);
      answer_t a;
      if (answer_queue.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual %h/%h/%h/%h",
                 $time, status, found, node, weight);
        return;
      end
      a = answer_queue.pop_front();
      field_check("status", WEIGHT_W'(a.status), WEIGHT_W'(status));
      field_check("found", WEIGHT_W'(a.found), WEIGHT_W'(found));
      field_check("closest_node", WEIGHT_W'(a.node), WEIGHT_W'(node));
      field_check("nearest_weight", a.weight, weight);
    endfunction

    function int pending();
      return answer_queue.size();
    endfunction

    function void flush_check();
      if (answer_queue.size() != 0) begin
        $display("%0t: %0d answers never arrived, expected status %0d actual none",
                 $time, answer_queue.size(), answer_queue[0].status);
        errors += answer_queue.size();
      end
    endfunction
  endclass

endpackage

// ===== tb/adjacency_table_nearest_neighbour_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for adjacency_table_nearest_neighbour_top: directed edge and
// query items, then random traffic, checked against a mirrored edge table.
// Depends on adj_nn_pkg, adj_nn_tb_pkg and the block's RTL.
module adjacency_table_nearest_neighbour_top_tb;
  import adj_nn_pkg::*;
  import adj_nn_tb_pkg::*;

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 7;
  localparam int ITEMS_PER_PHASE  = 509;
  // Longest item is a query over a full list; leave slack.
  localparam int SETTLE_CYCLES    = 30;
  localparam int DRAIN_GUARD      = 5000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 command;
  logic [NODE_IN_W-1:0] src_node;
  logic [NODE_IN_W-1:0] dst_node;
  logic [WEIGHT_W-1:0]  edge_weight;
  logic                 is_directed;
  logic                 done;
  logic [1:0]           status;
  logic                 found;
  logic [NODE_IN_W-1:0] closest_node;
  logic [WEIGHT_W-1:0]  nearest_weight;

  adjacency_mirror mirror;
  int items_sent;
  int idle_pct;

  adjacency_table_nearest_neighbour_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .src_node       (src_node),
    .dst_node       (dst_node),
    .edge_weight    (edge_weight),
    .is_directed    (is_directed),
    .done           (done),
    .status         (status),
    .found          (found),
    .closest_node   (closest_node),
    .nearest_weight (nearest_weight)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results last one cycle and cannot be held off: sample every edge.
  always @(posedge clk) begin
    if (!rst && done) mirror.check_answer(status, found, closest_node, nearest_weight);
  end

  // Drop start for one cycle and put garbage on the fields, which the block
  // must ignore while start is low.
  task automatic idle_cycle();
    @(negedge clk);
    start       <= 1'b0;
    command     <= 1'($urandom);
    src_node    <= NODE_IN_W'($urandom);
    dst_node    <= NODE_IN_W'($urandom);
    edge_weight <= WEIGHT_W'($urandom);
    is_directed <= 1'($urandom);
  endtask

  // Present one item and hold it until an edge sees start high with busy low.
  // Start stays high on return, so a back-to-back item raises it only once.
  task automatic send_item(command_t cmd, logic [NODE_IN_W-1:0] src,
                           logic [NODE_IN_W-1:0] dst, logic [WEIGHT_W-1:0] w,
                           logic directed);
    @(negedge clk);
    start       <= 1'b1;
    command     <= cmd;
    src_node    <= src;
    dst_node    <= dst;
    edge_weight <= w;
    is_directed <= directed;
    do @(posedge clk); while (busy);
    mirror.apply_command(cmd, src, dst, w, directed);
    items_sent++;
  endtask

  // Hold start low until every predicted answer has come back.
  task automatic wait_for_answers();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (mirror.pending() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // Random item: mostly a hot group of nodes per phase so lists fill and long
  // walks happen, the rest anywhere in the table; weights lean to extremes
  // and to a tiny range that forces ties.
  task automatic random_item(int phase);
    command_t             cmd;
    logic [NODE_IN_W-1:0] src;
    logic [NODE_IN_W-1:0] dst;
    logic [WEIGHT_W-1:0]  w;
    cmd = ($urandom_range(99) < 45) ? CMD_ADD : CMD_QUERY;
    src = ($urandom_range(99) < 60) ? NODE_IN_W'(phase * 20 + $urandom_range(7))
                                    : NODE_IN_W'($urandom);
    if ($urandom_range(9) == 0)
      dst = src;
    else if ($urandom_range(99) < 60)
      dst = NODE_IN_W'(phase * 20 + $urandom_range(7));
    else
      dst = NODE_IN_W'($urandom);
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2, 3:    w = WEIGHT_W'($urandom_range(3));
      default: w = WEIGHT_W'($urandom);
    endcase
    send_item(cmd, src, dst, w, 1'($urandom));
  endtask

  initial begin
    int phase;
    int n;
    mirror      = new();
    items_sent  = 0;
    idle_pct    = 0;
    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_ADD;
    src_node    = '0;
    dst_node    = '0;
    edge_weight = '0;
    is_directed = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty node, extreme weights and nodes, both directions,
    // first of equal minima winning.
    send_item(CMD_QUERY, 6'd0, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_ADD, 6'd0, 6'd63, 16'hFFFF, 1'b1);
    send_item(CMD_ADD, 6'd0, 6'd1, 16'h0000, 1'b0);
    send_item(CMD_QUERY, 6'd0, 6'd63, 16'hFFFF, 1'b1);
    send_item(CMD_QUERY, 6'd63, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_QUERY, 6'd1, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_ADD, 6'd2, 6'd10, 16'h0100, 1'b1);
    send_item(CMD_ADD, 6'd2, 6'd11, 16'h0100, 1'b1);
    send_item(CMD_QUERY, 6'd2, 6'd0, 16'h0000, 1'b0);

    // Fill node 7 with undirected self loops (two entries each) to 14, add one
    // tie to reach 15, then a self loop must be refused for want of two slots.
    for (int k = 0; k < 7; k++)
      send_item(CMD_ADD, 6'd7, 6'd7, 16'(32'h7000 - k * 32'h1000), 1'b0);
    send_item(CMD_ADD, 6'd7, 6'd12, 16'h1000, 1'b1);
    send_item(CMD_ADD, 6'd7, 6'd7, 16'h0001, 1'b0);
    send_item(CMD_ADD, 6'd7, 6'd13, 16'h0FFF, 1'b1);
    // Node 7 is full now: refuse as source, as undirected source and as
    // undirected destination; node 9 must stay empty.
    send_item(CMD_ADD, 6'd7, 6'd14, 16'h0000, 1'b1);
    send_item(CMD_ADD, 6'd7, 6'd8, 16'h0000, 1'b0);
    send_item(CMD_ADD, 6'd9, 6'd7, 16'h0000, 1'b0);
    send_item(CMD_QUERY, 6'd7, 6'd0, 16'h0000, 1'b0);
    send_item(CMD_QUERY, 6'd9, 6'd0, 16'h0000, 1'b0);

    // Random part in three phases of sender idling, with one full drain in
    // the middle of each.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 9;
        1:       idle_pct = 53;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_for_answers();
        while ($urandom_range(99) < idle_pct) idle_cycle();
        random_item(phase);
      end
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
    mirror.flush_check();

    $display("covered %0d items: %0d edges stored, %0d adds refused on full lists,",
             items_sent, mirror.adds_stored, mirror.adds_full);
    $display("%0d queries answered with a neighbor, %0d queries on empty nodes",
             mirror.hits, mirror.misses);
    if (mirror.errors == 0) begin
      $display("adjacency_table_nearest_neighbour_top_tb: clean");
    end else begin
      $display("adjacency_table_nearest_neighbour_top_tb: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(64'd10_000_000);
    $display("%0t: timeout with %0d answers outstanding", $time, mirror.pending());
    $display("adjacency_table_nearest_neighbour_top_tb: errors");
    $finish;
  end

endmodule
